// ----- hw/rtl/spa_pkg.sv -----
// Shared types and codes of the slot pool allocator.
package spa_pkg;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_WALK    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_REFUSED  = 2'd1,
    ERR_NOT_USED = 2'd2,
    ERR_END      = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LINK
  } seq_state_t;

  typedef struct packed {
    kind_t      kind;
    logic       granted;
    logic [4:0] slot;
    logic       from_head;
  } item_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] slot;
    err_t       err;
  } result_t;

endpackage

// ----- hw/rtl/slot_pool_allocator.sv -----
// Top level of the slot pool allocator: stream ports, link memories, result register.
//
// Manages POOL_SIZE slots as a LIFO free list and a doubly linked used list kept
// in three memories (forward links, back links, in-use bits), each with one write
// and one read port. After reset a clearing pass over every slot rebuilds the
// free list in ascending order; s_tready stays low for that time. Each word then
// passes an accept step (ST_IDLE) and a lookup step (ST_EXEC) for a walk, a
// refused allocate, a failed release or an unused kind code; a successful
// allocate or release adds a link step (ST_LINK) that patches the neighbor
// links through the single write port of each link memory. The result sits
// in an output register, so the next word is taken while the previous result
// waits; a result that cannot be posted holds the sequencer in its last step.
module slot_pool_allocator #(
  parameter int POOL_SIZE = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [0] sprite_granted, [5:1] slot, [6] from_head, [7] zero
  input  logic [1:0] s_tuser,   // [1:0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] ok, [5:1] result_slot, [7:6] error_code
);
  import spa_pkg::*;

  localparam int AW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);

  item_t   item;
  result_t result;
  logic    post, out_free;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] next_rdata, prev_rdata;
  logic          use_rdata;
  logic          next_we, prev_we, use_we;
  logic [AW-1:0] next_waddr, prev_waddr, use_waddr;
  logic [LW-1:0] next_wdata, prev_wdata;
  logic          use_wdata;

  // Unpack the incoming word.
  assign item.kind      = kind_t'(s_tuser);
  assign item.granted   = s_tdata[0];
  assign item.slot      = s_tdata[5:1];
  assign item.from_head = s_tdata[6];

  // The result register is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  spa_seq #(.POOL_SIZE(POOL_SIZE)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .item       (item),
    .out_free   (out_free),
    .post       (post),
    .result     (result),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata),
    .use_rdata  (use_rdata),
    .next_we    (next_we),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_we    (prev_we),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .use_we     (use_we),
    .use_waddr  (use_waddr),
    .use_wdata  (use_wdata)
  );

  // Forward links: free list and used list share them.
  spa_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (next_rdata)
  );

  // Back links of the used list.
  spa_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (prev_rdata)
  );

  // In-use flags.
  spa_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_use_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (use_waddr),
    .wdata (use_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (use_rdata)
  );

  // Hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (post) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      m_tdata <= {result.err, result.slot, result.ok};
    end
  end

endmodule

// ----- hw/rtl/spa_ram.sv -----
// Simple dual-port memory: one write port, one registered read port.
module spa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/spa_seq.sv -----
// Sequencer: list heads, link updates over the shared memory ports, results.
module spa_seq #(
  parameter int POOL_SIZE = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  spa_pkg::item_t                   item,
  input  logic                             out_free,
  output logic                             post,
  output spa_pkg::result_t                 result,
  output logic                             rd_en,
  output logic [$clog2(POOL_SIZE)-1:0]     rd_addr,
  input  logic [$clog2(POOL_SIZE+1)-1:0]   next_rdata,
  input  logic [$clog2(POOL_SIZE+1)-1:0]   prev_rdata,
  input  logic                             use_rdata,
  output logic                             next_we,
  output logic [$clog2(POOL_SIZE)-1:0]     next_waddr,
  output logic [$clog2(POOL_SIZE+1)-1:0]   next_wdata,
  output logic                             prev_we,
  output logic [$clog2(POOL_SIZE)-1:0]     prev_waddr,
  output logic [$clog2(POOL_SIZE+1)-1:0]   prev_wdata,
  output logic                             use_we,
  output logic [$clog2(POOL_SIZE)-1:0]     use_waddr,
  output logic                             use_wdata
);
  import spa_pkg::*;

  localparam int AW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SIZE);
  localparam logic [AW-1:0] LAST_IDX  = AW'(POOL_SIZE - 1);

  seq_state_t    state, state_next;
  item_t         item_q;
  logic [LW-1:0] free_head, used_head;
  logic [LW-1:0] p_q, n_q;
  logic [AW-1:0] clr_idx;

  logic          slot_ok, alloc_go, walk_end;
  logic [LW-1:0] walk_f;

  assign slot_ok  = (32'(item_q.slot) < 32'(POOL_SIZE)) && use_rdata;
  assign alloc_go = (free_head != NULL_LINK) && item_q.granted;
  assign walk_f   = item_q.from_head ? used_head : next_rdata;
  assign walk_end = walk_f == NULL_LINK;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if ((item_q.kind == KIND_ALLOC && alloc_go) ||
            (item_q.kind == KIND_RELEASE && slot_ok)) begin
          state_next = ST_LINK;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_LINK:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    in_ready   = 1'b0;
    post       = 1'b0;
    result     = '{ok: 1'b0, slot: 5'd0, err: ERR_NONE};
    rd_en      = 1'b0;
    rd_addr    = (item.kind == KIND_ALLOC) ? AW'(free_head) : AW'(item.slot);
    next_we    = 1'b0;
    next_waddr = AW'(item_q.slot);
    next_wdata = free_head;
    prev_we    = 1'b0;
    prev_waddr = AW'(item_q.slot);
    prev_wdata = NULL_LINK;
    use_we     = 1'b0;
    use_waddr  = AW'(item_q.slot);
    use_wdata  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        next_we    = 1'b1;
        next_waddr = clr_idx;
        next_wdata = LW'(clr_idx) + LW'(1);
        prev_we    = 1'b1;
        prev_waddr = clr_idx;
        use_we     = 1'b1;
        use_waddr  = clr_idx;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
      end
      ST_EXEC: begin
        unique case (item_q.kind)
          KIND_ALLOC: begin
            if (alloc_go) begin
              // Link the taken slot in front of the used list.
              next_we    = 1'b1;
              next_waddr = AW'(free_head);
              next_wdata = used_head;
              prev_we    = 1'b1;
              prev_waddr = AW'(free_head);
              use_we     = 1'b1;
              use_waddr  = AW'(free_head);
              use_wdata  = 1'b1;
            end else begin
              post   = out_free;
              result = '{ok: 1'b0, slot: 5'd0, err: ERR_REFUSED};
            end
          end
          KIND_RELEASE: begin
            if (slot_ok) begin
              // Push the slot onto the free list.
              next_we = 1'b1;
              prev_we = 1'b1;
              use_we  = 1'b1;
            end else begin
              post   = out_free;
              result = '{ok: 1'b0, slot: 5'd0, err: ERR_NOT_USED};
            end
          end
          KIND_WALK: begin
            post = out_free;
            if (!item_q.from_head && !slot_ok) begin
              result = '{ok: 1'b0, slot: 5'd0, err: ERR_NOT_USED};
            end else if (walk_end) begin
              result = '{ok: 1'b0, slot: 5'd0, err: ERR_END};
            end else begin
              result = '{ok: 1'b1, slot: 5'(walk_f), err: ERR_NONE};
            end
          end
          default: begin
            post = out_free;
          end
        endcase
      end
      ST_LINK: begin
        post = out_free;
        if (item_q.kind == KIND_ALLOC) begin
          result = '{ok: 1'b1, slot: 5'(p_q), err: ERR_NONE};
        end else begin
          result = '{ok: 1'b1, slot: 5'd0, err: ERR_NONE};
        end
        // Patch the neighbors: predecessor forward link (release only), successor back link.
        next_we    = out_free && (item_q.kind == KIND_RELEASE) && (p_q != NULL_LINK);
        next_waddr = AW'(p_q);
        next_wdata = n_q;
        prev_we    = out_free && (n_q != NULL_LINK);
        prev_waddr = AW'(n_q);
        prev_wdata = p_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      free_head <= '0;
      used_head <= NULL_LINK;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (state == ST_EXEC && item_q.kind == KIND_ALLOC && alloc_go) begin
        free_head <= next_rdata;
        used_head <= free_head;
      end
      if (state == ST_EXEC && item_q.kind == KIND_RELEASE && slot_ok) begin
        free_head <= LW'(item_q.slot);
        if (prev_rdata == NULL_LINK) begin
          used_head <= next_rdata;
        end
      end
    end
  end

  // Hold the item and the neighbor links for the patch-up cycle.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item_q <= item;
    end
    if (state == ST_EXEC) begin
      if (item_q.kind == KIND_ALLOC) begin
        p_q <= free_head;
        n_q <= used_head;
      end else begin
        p_q <= prev_rdata;
        n_q <= next_rdata;
      end
    end
  end

endmodule

// ----- sim/slot_pool_allocator_test.sv -----
// Self-checking testbench of the slot pool allocator: directed and random allocate, release, walk.
module slot_pool_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;

  localparam int WORDS_PER_PHASE = 160;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 400000;

  // Tracks the free stack and the used chain of the pool and holds the
  // results due from the block, oldest first.
  class slot_ledger;
    localparam logic [5:0] NO_SLOT = 6'd32;

    logic [5:0] fwd[32];
    logic [5:0] back[32];
    bit         busy[32];
    logic [5:0] free_top;
    logic [5:0] used_top;
    result_t    due[$];
    int         errors;
    int         words;
    int         kind_seen[4];
    int         err_seen[4];

    function new();
      for (int i = 0; i < 32; i++) begin
        fwd[i]  = 6'(i + 1);
        back[i] = NO_SLOT;
        busy[i] = 1'b0;
      end
      free_top = 6'd0;
      used_top = NO_SLOT;
      errors   = 0;
      words    = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (err_seen[i]) err_seen[i] = 0;
    endfunction

    function int in_flight();
      return due.size();
    endfunction

    function int pick_busy();
      int picks[$];
      for (int i = 0; i < 32; i++)
        if (busy[i]) picks.push_back(i);
      if (picks.size() == 0) return -1;
      return picks[$urandom_range(picks.size() - 1)];
    endfunction

    // Apply one accepted word to the lists and queue the result it gives.
    function void note_word(item_t w);
      result_t    r;
      logic [5:0] a;
      logic [5:0] p;
      logic [5:0] n;
      logic [5:0] f;
      r.ok   = 1'b0;
      r.slot = 5'd0;
      r.err  = ERR_NONE;
      case (w.kind)
        KIND_ALLOC: begin
          if (free_top == NO_SLOT || !w.granted) begin
            r.err = ERR_REFUSED;
          end else begin
            a = free_top;
            free_top = fwd[a[4:0]];
            fwd[a[4:0]] = used_top;
            if (used_top != NO_SLOT) back[used_top[4:0]] = a;
            back[a[4:0]] = NO_SLOT;
            used_top = a;
            busy[a[4:0]] = 1'b1;
            r.ok = 1'b1;
            r.slot = a[4:0];
          end
        end
        KIND_RELEASE: begin
          if (!busy[w.slot]) begin
            r.err = ERR_NOT_USED;
          end else begin
            p = back[w.slot];
            n = fwd[w.slot];
            if (p != NO_SLOT) fwd[p[4:0]] = n;
            else used_top = n;
            if (n != NO_SLOT) back[n[4:0]] = p;
            back[w.slot] = NO_SLOT;
            fwd[w.slot] = free_top;
            free_top = {1'b0, w.slot};
            busy[w.slot] = 1'b0;
            r.ok = 1'b1;
          end
        end
        KIND_WALK: begin
          if (!w.from_head && !busy[w.slot]) begin
            r.err = ERR_NOT_USED;
          end else begin
            f = w.from_head ? used_top : fwd[w.slot];
            if (f == NO_SLOT) begin
              r.err = ERR_END;
            end else begin
              r.ok = 1'b1;
              r.slot = f[4:0];
            end
          end
        end
        default: ;
      endcase
      words++;
      kind_seen[w.kind]++;
      err_seen[r.err]++;
      due.push_back(r);
    endfunction

    // Compare one posted result with the oldest one due.
    function void check_word(logic [7:0] data);
      result_t want;
      if (due.size() == 0) begin
        $display("%0t: result 0x%02h arrived with none due", $time, data);
        errors++;
        return;
      end
      want = due.pop_front();
      if (data[0] !== want.ok) begin
        $display("%0t: ok mismatch: expected %0d actual %0d", $time, want.ok, data[0]);
        errors++;
      end
      if (data[5:1] !== want.slot) begin
        $display("%0t: result_slot mismatch: expected %0d actual %0d",
                 $time, want.slot, data[5:1]);
        errors++;
      end
      if (data[7:6] !== want.err) begin
        $display("%0t: error_code mismatch: expected %0d actual %0d",
                 $time, want.err, data[7:6]);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic [1:0] s_tuser = 2'd0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  slot_ledger ledger;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;
  int words_sent = 0;

  slot_pool_allocator #(.POOL_SIZE(32)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check each word taken, stall at random, and hold off for a
  // long stretch when asked.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) ledger.check_word(m_tdata);
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one word and hold it until taken; valid stays high afterwards.
  task automatic send_word(kind_t k, logic g, logic [4:0] s, logic fh);
    item_t w;
    w.kind = k;
    w.granted = g;
    w.slot = s;
    w.from_head = fh;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, fh, s, g};
    s_tuser <= k;
    do @(posedge clk); while (!s_tready);
    ledger.note_word(w);
    words_sent++;
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.in_flight() != 0) @(posedge clk);
  endtask

  // Release a slot in use most of the time, any slot otherwise.
  task automatic send_release();
    int pick;
    pick = ledger.pick_busy();
    if (pick < 0 || $urandom_range(99) < 15) pick = $urandom_range(31);
    send_word(KIND_RELEASE, 1'($urandom), 5'(pick), 1'($urandom));
  endtask

  // One burst of random shape: fill, drain, a full traversal, a mix or noise.
  task automatic run_burst();
    int pick;
    int n;
    logic [5:0] cur;
    case ($urandom_range(9))
      0, 1, 2: begin
        n = $urandom_range(1, 40);
        repeat (n) send_word(KIND_ALLOC, ($urandom_range(19) != 0), 5'($urandom), 1'($urandom));
      end
      3, 4: begin
        n = $urandom_range(1, 32);
        repeat (n) send_release();
      end
      5, 6: begin
        send_word(KIND_WALK, 1'($urandom), 5'($urandom), 1'b1);
        cur = ledger.used_top;
        n = 0;
        while (cur != 6'd32 && n < 40) begin
          send_word(KIND_WALK, 1'($urandom), cur[4:0], 1'b0);
          cur = ledger.fwd[cur[4:0]];
          n++;
        end
      end
      7, 8: begin
        n = $urandom_range(4, 24);
        repeat (n) begin
          pick = $urandom_range(99);
          if (pick < 35) begin
            send_word(KIND_ALLOC, ($urandom_range(9) != 0), 5'($urandom), 1'($urandom));
          end else if (pick < 70) begin
            send_release();
          end else if (pick < 97) begin
            pick = ledger.pick_busy();
            if (pick < 0 || $urandom_range(99) < 20) pick = $urandom_range(31);
            send_word(KIND_WALK, 1'($urandom), 5'(pick), ($urandom_range(99) < 30));
          end else begin
            send_word(KIND_NONE, 1'($urandom), 5'($urandom), 1'($urandom));
          end
        end
      end
      default: begin
        n = $urandom_range(1, 8);
        repeat (n) send_word(kind_t'($urandom_range(3)), 1'($urandom), 5'($urandom),
                             1'($urandom));
      end
    endcase
  endtask

  initial begin
    ledger = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed opening on a fresh pool.
    send_word(KIND_WALK, 1'b0, 5'd0, 1'b1);       // empty used list: end of list
    send_word(KIND_RELEASE, 1'b1, 5'd0, 1'b0);    // slot never used
    send_word(KIND_RELEASE, 1'b1, 5'd31, 1'b1);   // top slot never used
    send_word(KIND_WALK, 1'b1, 5'd31, 1'b0);      // walk from an unused slot
    send_word(KIND_ALLOC, 1'b0, 5'd0, 1'b0);      // sprite denied
    send_word(KIND_NONE, 1'b1, 5'd31, 1'b1);      // unused kind code, fields all ones
    send_word(KIND_ALLOC, 1'b1, 5'd0, 1'b0);
    send_word(KIND_ALLOC, 1'b1, 5'd31, 1'b1);
    send_word(KIND_ALLOC, 1'b1, 5'd0, 1'b0);
    send_word(KIND_WALK, 1'b0, 5'd0, 1'b1);       // head is the newest slot
    send_word(KIND_WALK, 1'b0, 5'd2, 1'b0);
    send_word(KIND_WALK, 1'b0, 5'd0, 1'b0);       // tail: successor is null
    send_word(KIND_WALK, 1'b1, 5'd31, 1'b1);      // from head ignores the slot field
    send_word(KIND_RELEASE, 1'b0, 5'd1, 1'b0);    // unlink from the middle
    send_word(KIND_RELEASE, 1'b0, 5'd2, 1'b0);    // unlink the head
    send_word(KIND_RELEASE, 1'b0, 5'd0, 1'b0);    // unlink the last one
    send_word(KIND_RELEASE, 1'b0, 5'd0, 1'b0);    // second release of the same slot
    send_word(KIND_WALK, 1'b0, 5'd0, 1'b1);
    send_word(KIND_ALLOC, 1'b1, 5'd0, 1'b0);      // LIFO reuse of the last freed slot
    send_word(KIND_ALLOC, 1'b0, 5'd31, 1'b1);
    send_word(KIND_NONE, 1'b0, 5'd0, 1'b0);
    pause_until_drained();

    // Random bursts under each idling profile; the last one adds a long hold-off.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        3: begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_requests++;
        end
      endcase
      begin
        int target;
        target = words_sent + WORDS_PER_PHASE;
        while (words_sent < target) run_burst();
      end
      pause_until_drained();
    end

    recv_stall_pct = 0;
    while (ledger.in_flight() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d words: %0d allocate, %0d release, %0d walk, %0d unused kind",
             ledger.words, ledger.kind_seen[KIND_ALLOC], ledger.kind_seen[KIND_RELEASE],
             ledger.kind_seen[KIND_WALK], ledger.kind_seen[KIND_NONE]);
    $display("outcomes: %0d refused, %0d not in use, %0d end of list, %0d clean",
             ledger.err_seen[ERR_REFUSED], ledger.err_seen[ERR_NOT_USED],
             ledger.err_seen[ERR_END], ledger.err_seen[ERR_NONE]);
    if (ledger.errors == 0 && ledger.in_flight() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/spa_pkg.sv
hw/rtl/spa_ram.sv
hw/rtl/spa_seq.sv
hw/rtl/slot_pool_allocator.sv
sim/slot_pool_allocator_test.sv
